### rtl/dvi_position_register_stack_macros.svh
// Assertion macros for the checker of the position register stack.
`ifndef DVI_POSITION_REGISTER_STACK_MACROS_SVH
`define DVI_POSITION_REGISTER_STACK_MACROS_SVH

// Clocked on clk, quiet while rst_n is low.
`define DVI_PRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, also checked through reset.
`define DVI_PRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dvi_prs_pkg.sv
package dvi_prs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int FUNC_W  = 4;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 27;
  localparam int LEVEL_W = 5;

  // Width scaling: at-size is brought below 2^23, alpha starts at 16, beta is 256 / alpha.
  localparam int SCALE_W  = 23;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = BYTE_W + SCALE_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int SHIFT_W  = 3;
  localparam int ALPHA_SH = 4;
  localparam int BETA_SH  = 8 - ALPHA_SH;

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_RIGHT  = 4'd0,
    FN_W_LOAD = 4'd1,
    FN_W_REP  = 4'd2,
    FN_X_LOAD = 4'd3,
    FN_X_REP  = 4'd4,
    FN_DOWN   = 4'd5,
    FN_Y_LOAD = 4'd6,
    FN_Y_REP  = 4'd7,
    FN_Z_LOAD = 4'd8,
    FN_Z_REP  = 4'd9,
    FN_PUSH   = 4'd10,
    FN_POP    = 4'd11,
    FN_CHAR   = 4'd12,
    FN_RULE   = 4'd13
  } func_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD_H,
    OP_ADD_V,
    OP_REP,
    OP_PUSH,
    OP_POP
  } op_t;

  typedef enum logic [1:0] {
    SP_W,
    SP_X,
    SP_Y,
    SP_Z
  } space_sel_t;

  typedef struct packed {
    op_t               op;
    logic              load;
    space_sel_t        sel;
    logic [DATA_W-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] h;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } frame_t;

endpackage

### rtl/dvi_prs_if.sv
interface dvi_prs_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [dvi_prs_pkg::FUNC_W-1:0]    func;
  logic signed [dvi_prs_pkg::DATA_W-1:0]    distance;
  logic        [dvi_prs_pkg::DATA_W-1:0]    fix_word;
  logic        [dvi_prs_pkg::SIZE_W-1:0]    font_size;

  modport source (output valid, func, distance, fix_word, font_size, input ready);
  modport sink   (input valid, func, distance, fix_word, font_size, output ready);
endinterface

interface dvi_prs_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [dvi_prs_pkg::DATA_W-1:0]    h_pos;
  logic signed [dvi_prs_pkg::DATA_W-1:0]    v_pos;
  logic        [dvi_prs_pkg::LEVEL_W-1:0]   stack_level;
  logic                                     stack_error;

  modport source (output valid, h_pos, v_pos, stack_level, stack_error, input ready);
  modport sink   (input valid, h_pos, v_pos, stack_level, stack_error, output ready);
endinterface

### rtl/dvi_prs_front.sv
module dvi_prs_front (
  input  logic                clk,
  input  logic                rst_n,
  dvi_prs_in_if.sink          in_chan,
  output dvi_prs_pkg::cmd_t   cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);

  // stage 1: classified command, reduced at-size and shift count
  logic                                 s1_v_r;
  dvi_prs_pkg::cmd_t                    s1_cmd_r;
  logic                                 s1_char_r;
  logic [dvi_prs_pkg::SCALE_W-1:0]      s1_scale_r;
  logic [dvi_prs_pkg::SHIFT_W-1:0]      s1_k_r;
  logic [dvi_prs_pkg::DATA_W-1:0]       s1_fix_r;
  // stage 2: byte products
  logic                                 s2_v_r;
  dvi_prs_pkg::cmd_t                    s2_cmd_r;
  logic                                 s2_char_r;
  logic [dvi_prs_pkg::PROD_W-1:0]       s2_b1_r;
  logic [dvi_prs_pkg::PROD_W-1:0]       s2_b2_r;
  logic [dvi_prs_pkg::PROD_W-1:0]       s2_b3_r;
  logic                                 s2_neg_r;
  logic [dvi_prs_pkg::SHIFT_W-1:0]      s2_k_r;
  logic [dvi_prs_pkg::DATA_W-1:0]       s2_alpha_r;
  // stage 3: accumulated sum
  logic                                 s3_v_r;
  dvi_prs_pkg::cmd_t                    s3_cmd_r;
  logic                                 s3_char_r;
  logic [dvi_prs_pkg::SUM_W-1:0]        s3_sum_r;
  logic                                 s3_neg_r;
  logic [dvi_prs_pkg::SHIFT_W-1:0]      s3_k_r;
  logic [dvi_prs_pkg::DATA_W-1:0]       s3_alpha_r;

  logic                                 en1, en2, en3;
  dvi_prs_pkg::cmd_t                    in_cmd;
  logic                                 in_char;
  logic [dvi_prs_pkg::SHIFT_W-1:0]      in_k;
  logic [dvi_prs_pkg::SIZE_W-1:0]       in_shifted;
  logic [dvi_prs_pkg::PROD_W:0]         part_sum;
  logic [dvi_prs_pkg::SUM_W-1:0]        full_sum;
  logic [dvi_prs_pkg::SHIFT_W-1:0]      beta_sh;
  logic [dvi_prs_pkg::SUM_W-1:0]        quotient;
  logic [dvi_prs_pkg::DATA_W-1:0]       char_w;

  assign en3 = !s3_v_r || cmd_ready;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_chan.ready = en1;

  always_comb begin
    in_cmd         = '0;
    in_cmd.op      = dvi_prs_pkg::OP_NOP;
    in_cmd.sel     = dvi_prs_pkg::SP_W;
    in_cmd.operand = in_chan.distance;
    in_char        = 1'b0;
    case (dvi_prs_pkg::func_t'(in_chan.func))
      dvi_prs_pkg::FN_RIGHT, dvi_prs_pkg::FN_RULE: begin
        in_cmd.op = dvi_prs_pkg::OP_ADD_H;
      end
      dvi_prs_pkg::FN_W_LOAD: begin
        in_cmd.op   = dvi_prs_pkg::OP_ADD_H;
        in_cmd.load = 1'b1;
        in_cmd.sel  = dvi_prs_pkg::SP_W;
      end
      dvi_prs_pkg::FN_W_REP: begin
        in_cmd.op  = dvi_prs_pkg::OP_REP;
        in_cmd.sel = dvi_prs_pkg::SP_W;
      end
      dvi_prs_pkg::FN_X_LOAD: begin
        in_cmd.op   = dvi_prs_pkg::OP_ADD_H;
        in_cmd.load = 1'b1;
        in_cmd.sel  = dvi_prs_pkg::SP_X;
      end
      dvi_prs_pkg::FN_X_REP: begin
        in_cmd.op  = dvi_prs_pkg::OP_REP;
        in_cmd.sel = dvi_prs_pkg::SP_X;
      end
      dvi_prs_pkg::FN_DOWN: begin
        in_cmd.op = dvi_prs_pkg::OP_ADD_V;
      end
      dvi_prs_pkg::FN_Y_LOAD: begin
        in_cmd.op   = dvi_prs_pkg::OP_ADD_V;
        in_cmd.load = 1'b1;
        in_cmd.sel  = dvi_prs_pkg::SP_Y;
      end
      dvi_prs_pkg::FN_Y_REP: begin
        in_cmd.op  = dvi_prs_pkg::OP_REP;
        in_cmd.sel = dvi_prs_pkg::SP_Y;
      end
      dvi_prs_pkg::FN_Z_LOAD: begin
        in_cmd.op   = dvi_prs_pkg::OP_ADD_V;
        in_cmd.load = 1'b1;
        in_cmd.sel  = dvi_prs_pkg::SP_Z;
      end
      dvi_prs_pkg::FN_Z_REP: begin
        in_cmd.op  = dvi_prs_pkg::OP_REP;
        in_cmd.sel = dvi_prs_pkg::SP_Z;
      end
      dvi_prs_pkg::FN_PUSH: begin
        in_cmd.op = dvi_prs_pkg::OP_PUSH;
      end
      dvi_prs_pkg::FN_POP: begin
        in_cmd.op = dvi_prs_pkg::OP_POP;
      end
      dvi_prs_pkg::FN_CHAR: begin
        in_cmd.op = dvi_prs_pkg::OP_ADD_H;
        in_char   = 1'b1;
      end
      default: begin
        in_cmd.op = dvi_prs_pkg::OP_NOP;
      end
    endcase
  end

  // halve the at-size until it is below 2^23; each halving doubles alpha
  always_comb begin
    if (in_chan.font_size[26]) begin
      in_k = 3'd4;
    end else if (in_chan.font_size[25]) begin
      in_k = 3'd3;
    end else if (in_chan.font_size[24]) begin
      in_k = 3'd2;
    end else if (in_chan.font_size[23]) begin
      in_k = 3'd1;
    end else begin
      in_k = 3'd0;
    end
  end

  assign in_shifted = in_chan.font_size >> in_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= in_chan.valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd_r   <= in_cmd;
      s1_char_r  <= in_char;
      s1_scale_r <= in_shifted[dvi_prs_pkg::SCALE_W-1:0];
      s1_k_r     <= in_k;
      s1_fix_r   <= in_chan.fix_word;
    end
    if (en2) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_char_r  <= s1_char_r;
      s2_b1_r    <= s1_fix_r[23:16] * s1_scale_r;
      s2_b2_r    <= s1_fix_r[15:8] * s1_scale_r;
      s2_b3_r    <= s1_fix_r[7:0] * s1_scale_r;
      s2_neg_r   <= |s1_fix_r[31:24];
      s2_k_r     <= s1_k_r;
      s2_alpha_r <= dvi_prs_pkg::DATA_W'(s1_scale_r) << (dvi_prs_pkg::ALPHA_SH + s1_k_r);
    end
    if (en3) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_char_r  <= s2_char_r;
      s3_sum_r   <= full_sum;
      s3_neg_r   <= s2_neg_r;
      s3_k_r     <= s2_k_r;
      s3_alpha_r <= s2_alpha_r;
    end
  end

  assign part_sum = (dvi_prs_pkg::PROD_W + 1)'(s2_b2_r)
                  + (dvi_prs_pkg::PROD_W + 1)'(s2_b3_r >> 8);
  assign full_sum = dvi_prs_pkg::SUM_W'(s2_b1_r) + dvi_prs_pkg::SUM_W'(part_sum >> 8);

  // divide by beta, then subtract alpha for a negative fix-word
  assign beta_sh  = dvi_prs_pkg::SHIFT_W'(dvi_prs_pkg::BETA_SH) - s3_k_r;
  assign quotient = s3_sum_r >> beta_sh;
  assign char_w   = quotient[dvi_prs_pkg::DATA_W-1:0] - (s3_neg_r ? s3_alpha_r : '0);

  always_comb begin
    cmd = s3_cmd_r;
    if (s3_char_r) begin
      cmd.operand = char_w;
    end
  end

  assign cmd_valid = s3_v_r;

endmodule

### rtl/dvi_prs_queue.sv
module dvi_prs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  dvi_prs_pkg::cmd_t   wr_cmd,
  input  logic                wr_valid,
  output logic                wr_ready,
  output dvi_prs_pkg::cmd_t   rd_cmd,
  output logic                rd_valid,
  input  logic                rd_ready
);

  dvi_prs_pkg::cmd_t                  slot_r [dvi_prs_pkg::FQ_DEPTH];
  logic [dvi_prs_pkg::FQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dvi_prs_pkg::FQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dvi_prs_pkg::FQ_CNT_W-1:0]   count_r, count_nxt;
  logic                               push, pop;

  assign wr_ready = count_r < dvi_prs_pkg::FQ_CNT_W'(dvi_prs_pkg::FQ_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == dvi_prs_pkg::FQ_PTR_W'(dvi_prs_pkg::FQ_DEPTH - 1))
                 ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == dvi_prs_pkg::FQ_PTR_W'(dvi_prs_pkg::FQ_DEPTH - 1))
                 ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

### rtl/dvi_prs_back.sv
module dvi_prs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dvi_prs_pkg::cmd_t   cmd,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  dvi_prs_out_if.source       out_chan
);

  logic [dvi_prs_pkg::DATA_W-1:0]         h_r, h_nxt;
  logic [dvi_prs_pkg::DATA_W-1:0]         v_r, v_nxt;
  logic [3:0][dvi_prs_pkg::DATA_W-1:0]    space_r, space_nxt;
  logic [dvi_prs_pkg::DEPTH_W-1:0]        depth_r, depth_nxt;
  dvi_prs_pkg::frame_t                    stack_r [dvi_prs_pkg::STACK_DEPTH];

  logic                                   out_valid_r;
  logic [dvi_prs_pkg::DATA_W-1:0]         out_h_r, out_v_r;
  logic [dvi_prs_pkg::LEVEL_W-1:0]        out_level_r;
  logic                                   out_err_r;

  logic                                   take;
  logic                                   err;
  logic                                   push_en;
  logic [dvi_prs_pkg::DEPTH_W-1:0]        depth_m1;
  logic [dvi_prs_pkg::DATA_W-1:0]         rep_val;
  dvi_prs_pkg::frame_t                    pop_frame;
  dvi_prs_pkg::frame_t                    push_frame;

  assign cmd_ready = !out_valid_r || out_chan.ready;
  assign take      = cmd_valid && cmd_ready;
  assign depth_m1  = depth_r - dvi_prs_pkg::DEPTH_W'(1);
  assign rep_val   = space_r[cmd.sel];
  assign pop_frame = stack_r[depth_m1[dvi_prs_pkg::IDX_W-1:0]];

  assign push_frame.h = h_r;
  assign push_frame.v = v_r;
  assign push_frame.w = space_r[dvi_prs_pkg::SP_W];
  assign push_frame.x = space_r[dvi_prs_pkg::SP_X];
  assign push_frame.y = space_r[dvi_prs_pkg::SP_Y];
  assign push_frame.z = space_r[dvi_prs_pkg::SP_Z];

  always_comb begin
    h_nxt     = h_r;
    v_nxt     = v_r;
    space_nxt = space_r;
    depth_nxt = depth_r;
    err       = 1'b0;
    push_en   = 1'b0;
    case (cmd.op)
      dvi_prs_pkg::OP_ADD_H: begin
        h_nxt = h_r + cmd.operand;
        if (cmd.load) begin
          space_nxt[cmd.sel] = cmd.operand;
        end
      end
      dvi_prs_pkg::OP_ADD_V: begin
        v_nxt = v_r + cmd.operand;
        if (cmd.load) begin
          space_nxt[cmd.sel] = cmd.operand;
        end
      end
      dvi_prs_pkg::OP_REP: begin
        if (cmd.sel == dvi_prs_pkg::SP_W || cmd.sel == dvi_prs_pkg::SP_X) begin
          h_nxt = h_r + rep_val;
        end else begin
          v_nxt = v_r + rep_val;
        end
      end
      dvi_prs_pkg::OP_PUSH: begin
        // drop a push onto a full stack and flag it
        if (depth_r >= dvi_prs_pkg::DEPTH_W'(dvi_prs_pkg::STACK_DEPTH)) begin
          err = 1'b1;
        end else begin
          push_en   = 1'b1;
          depth_nxt = depth_r + dvi_prs_pkg::DEPTH_W'(1);
        end
      end
      dvi_prs_pkg::OP_POP: begin
        if (depth_r == '0) begin
          err = 1'b1;
        end else begin
          depth_nxt                      = depth_m1;
          h_nxt                          = pop_frame.h;
          v_nxt                          = pop_frame.v;
          space_nxt[dvi_prs_pkg::SP_W]   = pop_frame.w;
          space_nxt[dvi_prs_pkg::SP_X]   = pop_frame.x;
          space_nxt[dvi_prs_pkg::SP_Y]   = pop_frame.y;
          space_nxt[dvi_prs_pkg::SP_Z]   = pop_frame.z;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= '0;
      v_r         <= '0;
      space_r     <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        h_r     <= h_nxt;
        v_r     <= v_nxt;
        space_r <= space_nxt;
        depth_r <= depth_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_h_r     <= h_nxt;
      out_v_r     <= v_nxt;
      out_level_r <= dvi_prs_pkg::LEVEL_W'(depth_nxt);
      out_err_r   <= err;
    end
    if (take && push_en) begin
      stack_r[depth_r[dvi_prs_pkg::IDX_W-1:0]] <= push_frame;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.h_pos       = out_h_r;
  assign out_chan.v_pos       = out_v_r;
  assign out_chan.stack_level = out_level_r;
  assign out_chan.stack_error = out_err_r;

endmodule

### rtl/dvi_position_register_stack.sv
// DVI position register stack: executes one DVI positioning command per item
// and answers each with h, v, the stack level and an overflow/underflow flag.
// It sustains one item per clock unless the result channel stalls. Three front
// stages (command decode with at-size reduction, byte products, sum) scale the
// TFM fix-word for character commands, a two-entry command queue follows, and
// the execute stage updates h, v, w, x, y, z and the 16-deep stack and loads
// the result register in the same cycle. A push onto a full stack or a pop
// from an empty one is reported and leaves all state as it was; func codes 14
// and 15 change nothing.
module dvi_position_register_stack (
  input  logic            clk,
  input  logic            rst_n,
  dvi_prs_in_if.sink      in_chan,
  dvi_prs_out_if.source   out_chan
);

  dvi_prs_pkg::cmd_t  front_cmd;
  logic               front_valid;
  logic               front_ready;
  dvi_prs_pkg::cmd_t  back_cmd;
  logic               back_valid;
  logic               back_ready;

  dvi_prs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  dvi_prs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (back_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  dvi_prs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_chan  (out_chan)
  );

endmodule

### rtl/dvi_prs_checker.sv
`include "dvi_position_register_stack_macros.svh"

module dvi_prs_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [dvi_prs_pkg::DATA_W-1:0]       out_h_pos,
  input logic [dvi_prs_pkg::LEVEL_W-1:0]      out_stack_level,
  input logic                                 out_stack_error
);

  `DVI_PRS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_h_pos), "stalled result changed")
  `DVI_PRS_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid right after reset")
  `DVI_PRS_ASSERT(a_level_max, out_valid |-> out_stack_level <= dvi_prs_pkg::LEVEL_W'(dvi_prs_pkg::STACK_DEPTH), "stack level above depth")
  `DVI_PRS_ASSERT(a_err_edge, out_valid && out_stack_error |-> out_stack_level == '0 || out_stack_level == dvi_prs_pkg::LEVEL_W'(dvi_prs_pkg::STACK_DEPTH), "error with stack neither empty nor full")

endmodule

bind dvi_position_register_stack dvi_prs_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_h_pos       (out_chan.h_pos),
  .out_stack_level (out_chan.stack_level),
  .out_stack_error (out_chan.stack_error)
);
